[hw/rtl/bps_pkg.sv]
package bps_pkg;

  localparam int TIME_BITS = 16;
  localparam int LEN_BITS  = 16;
  localparam int CMP_BITS  = (TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS;
  localparam int IDX_BITS  = 3;
  localparam int PAT_BITS  = 3;
  localparam int CFG_IDX_BITS = 4;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_MUTE_ENABLE     = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CHIRP_LENGTH_MS = CFG_IDX_BITS'(1);

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PLAY = 1'b1;

  localparam logic [PAT_BITS-1:0] PAT_NONE   = 3'd0;
  localparam logic [PAT_BITS-1:0] PAT_CHIRP  = 3'd1;
  localparam logic [PAT_BITS-1:0] PAT_DOUBLE = 3'd2;
  localparam logic [PAT_BITS-1:0] PAT_LONG   = 3'd3;
  localparam logic [PAT_BITS-1:0] PAT_ALARM  = 3'd4;

  localparam logic [LEN_BITS-1:0] GAP_MS        = 16'd70;
  localparam logic [LEN_BITS-1:0] LONG_MS       = 16'd400;
  localparam logic [LEN_BITS-1:0] ALARM_ON_MS   = 16'd200;
  localparam logic [LEN_BITS-1:0] ALARM_OFF_MS  = 16'd150;
  localparam logic [LEN_BITS-1:0] ALARM_REST_MS = 16'd600;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef struct packed {
    logic                cmd;
    logic [PAT_BITS-1:0] pattern_code;
  } in_item_t;

  typedef struct packed {
    logic tone_on;
    logic playing;
  } out_item_t;

  typedef struct packed {
    logic                 active;
    logic [PAT_BITS-1:0]  pattern;
    logic [IDX_BITS-1:0]  seg_idx;
    logic [TIME_BITS-1:0] elapsed;
    logic                 tone;
  } seq_state_t;

  typedef struct packed {
    logic                on;
    logic                chirp;
    logic [LEN_BITS-1:0] ms;
  } seg_t;

  function automatic seg_t seg_lookup(logic [PAT_BITS-1:0] pat, logic [IDX_BITS-1:0] idx);
    seg_t s;
    s = '{on: 1'b0, chirp: 1'b0, ms: '0};
    case (pat)
      PAT_CHIRP: begin
        if (idx == 3'd0) s = '{on: 1'b1, chirp: 1'b1, ms: '0};
      end
      PAT_DOUBLE: begin
        case (idx)
          3'd0: s = '{on: 1'b1, chirp: 1'b1, ms: '0};
          3'd1: s = '{on: 1'b0, chirp: 1'b0, ms: GAP_MS};
          3'd2: s = '{on: 1'b1, chirp: 1'b1, ms: '0};
          default: s = '{on: 1'b0, chirp: 1'b0, ms: '0};
        endcase
      end
      PAT_LONG: begin
        if (idx == 3'd0) s = '{on: 1'b1, chirp: 1'b0, ms: LONG_MS};
      end
      PAT_ALARM: begin
        case (idx)
          3'd0, 3'd2, 3'd4: s = '{on: 1'b1, chirp: 1'b0, ms: ALARM_ON_MS};
          3'd1, 3'd3:       s = '{on: 1'b0, chirp: 1'b0, ms: ALARM_OFF_MS};
          3'd5:             s = '{on: 1'b0, chirp: 1'b0, ms: ALARM_REST_MS};
          3'd6:             s = '{on: 1'b1, chirp: 1'b0, ms: '0};
          default:          s = '{on: 1'b0, chirp: 1'b0, ms: '0};
        endcase
      end
      default: s = '{on: 1'b0, chirp: 1'b0, ms: '0};
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/bps_step.sv]
module bps_step
  import bps_pkg::*;
(
  input  in_item_t            item,
  input  seq_state_t          cur,
  input  logic                mute_enable,
  input  logic [LEN_BITS-1:0] chirp_length_ms,
  output seq_state_t          nxt
);

  seg_t                 seg;
  seg_t                 first_seg;
  seg_t                 restart_seg;
  seg_t                 next_seg;
  logic [LEN_BITS-1:0]  seg_len;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic                 start_code;

  always_comb begin
    seg         = seg_lookup(cur.pattern, cur.seg_idx);
    first_seg   = seg_lookup(item.pattern_code, '0);
    restart_seg = seg_lookup(cur.pattern, '0);
    next_seg    = seg_lookup(cur.pattern, cur.seg_idx + IDX_BITS'(1));
    seg_len   = seg.chirp ? chirp_length_ms : seg.ms;
    elapsed_inc = (cur.elapsed == TIME_MAX) ? cur.elapsed : cur.elapsed + TIME_BITS'(1);
    start_code = (item.pattern_code inside {[PAT_CHIRP:PAT_ALARM]});
    nxt = cur;
    if (item.cmd == CMD_PLAY) begin
      if (!(mute_enable && item.pattern_code != PAT_ALARM)) begin
        if (start_code) begin
          nxt.pattern = item.pattern_code;
          nxt.seg_idx = '0;
          nxt.elapsed = '0;
          nxt.active  = 1'b1;
          nxt.tone    = first_seg.on;
        end else begin
          nxt.active = 1'b0;
          nxt.tone   = 1'b0;
        end
      end
    end else if (cur.active) begin
      if (seg_len == '0) begin
        if (cur.pattern == PAT_ALARM) begin
          nxt.seg_idx = '0;
          nxt.elapsed = '0;
          nxt.tone    = restart_seg.on;
        end else begin
          nxt.active = 1'b0;
          nxt.tone   = 1'b0;
        end
      end else if (CMP_BITS'(elapsed_inc) >= CMP_BITS'(seg_len)) begin
        nxt.seg_idx = cur.seg_idx + IDX_BITS'(1);
        nxt.elapsed = '0;
        nxt.tone    = next_seg.on;
      end else begin
        nxt.elapsed = elapsed_inc;
      end
    end
  end

endmodule

[hw/rtl/buzzer_pattern_sequencer.sv]
// channel | signals                         | transfer when
// in      | in_valid, in_ready, in_data     | in_valid & in_ready
// out     | out_valid, out_ready, out_data  | out_valid & out_ready
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
// one item per cycle while in_ready is high; each result is registered
// state update is one pass through the segment rom and one 16-bit compare
// a skid register behind the output register holds one result while the output stalls
// in_ready drops only while the skid register holds a result; cfg_ready is always high
// synchronous active-low reset: idle, tone off, mute off, chirp length 50 ms
module buzzer_pattern_sequencer
  import bps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  seq_state_t          st_r, st_nxt;
  logic                mute_r;
  logic [LEN_BITS-1:0] chirp_len_r;
  logic                out_valid_r, skid_valid_r;
  out_item_t           out_data_r, skid_data_r, res;
  logic                push, pop;

  bps_step u_step (
    .item            (in_data),
    .cur             (st_r),
    .mute_enable     (mute_r),
    .chirp_length_ms (chirp_len_r),
    .nxt             (st_nxt)
  );

  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign res       = '{tone_on: st_nxt.tone, playing: st_nxt.active};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r      <= 1'b0;
      chirp_len_r <= LEN_BITS'(50);
    end else if (cfg_valid) begin
      if (cfg_index == REG_MUTE_ENABLE) mute_r <= cfg_data[0];
      else if (cfg_index == REG_CHIRP_LENGTH_MS) chirp_len_r <= cfg_data[LEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{active: 1'b0, pattern: PAT_NONE, seg_idx: '0, elapsed: '0, tone: 1'b0};
    end else if (push) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full with output register empty");

  // tone is only driven within an active pattern
  a_tone_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.tone |-> st_r.active)
    else $error("tone on while idle");

  // no pattern reaches the last rom slot
  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.seg_idx != {IDX_BITS{1'b1}})
    else $error("segment index out of range");

  // an accepted alarm request restarts cleanly
  a_alarm_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_data.cmd == CMD_PLAY && in_data.pattern_code == PAT_ALARM) |=>
      (st_r.active && st_r.tone && st_r.elapsed == '0 && st_r.seg_idx == '0))
    else $error("alarm request did not restart the pattern");

endmodule
